FILE: rtl/bootloader_download_sequencer_defines.svh
// Assertion macros shared by the download sequencer RTL.
// Depends on a clock named clk and an active-high reset named rst in the including scope.
`ifndef BOOTLOADER_DOWNLOAD_SEQUENCER_DEFINES_SVH
`define BOOTLOADER_DOWNLOAD_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define BDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define BDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bds_pkg.sv
// Shared types and constants of the bootloader download sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package bds_pkg;

  localparam int unsigned PAGE_BYTES = 128;

  // Frame length of a transfer request: service id plus one page of data.
  localparam logic [7:0] XFER_LEN  = 8'(PAGE_BYTES + 1);
  localparam logic [7:0] PAGE_LAST = 8'(PAGE_BYTES);
  localparam logic [15:0] PAGE_STEP = 16'(PAGE_BYTES);

  localparam logic [7:0] SID_SESSION     = 8'h10;
  localparam logic [7:0] SUB_PROGRAMMING = 8'h03;
  localparam logic [7:0] SID_DOWNLOAD    = 8'h34;
  localparam logic [7:0] SID_TRANSFER    = 8'h36;
  localparam logic [7:0] SID_EXIT        = 8'h37;
  localparam logic [7:0] SID_CRC         = 8'h31;
  localparam logic [7:0] RESP_NEG        = 8'h7F;
  localparam logic [7:0] RESP_OFFSET     = 8'h40;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] MAX_CODE_RESET = 16'h3800;

  typedef enum logic [4:0] {
    PH_SESSION = 5'b00001,
    PH_DLREQ   = 5'b00010,
    PH_XFER    = 5'b00100,
    PH_EXIT    = 5'b01000,
    PH_CRC     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } bds_req_t;

  typedef struct packed {
    logic       resp_valid;
    logic [7:0] resp_byte;
    logic       stage_valid;
    logic [6:0] stage_offset;
    logic [7:0] stage_byte;
    logic       commit_valid;
    logic [7:0] commit_page;
    logic       start_app;
  } bds_res_t;

  // Handshake control from the top level to the datapath modules.
  typedef struct packed {
    logic fire;
    logic emit;
  } bds_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/bds_crc.sv
// One-byte update of the reflected CRC-16 (polynomial 0xA001).
// Depends on bds_pkg for the polynomial.
`default_nettype none

module bds_crc
  import bds_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

FILE: rtl/bds_in_reg.sv
// Input register of the download sequencer: holds one accepted request.
// Depends on bds_pkg for the request type.
`default_nettype none

module bds_in_reg
  import bds_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  bds_req_t req,
  input  bds_ctl_t ctl,
  output logic     full,
  output bds_req_t item
);

  // The slot frees up in the same cycle that the core consumes it.
  assign req_ready = !full || ctl.fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (req_valid && req_ready) begin
      full <= 1'b1;
    end else if (ctl.fire) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bds_out_reg.sv
// Result register of the download sequencer: holds one result until taken.
// Depends on bds_pkg for the result type.
`default_nettype none

module bds_out_reg
  import bds_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  bds_ctl_t ctl,
  input  bds_res_t result,
  output logic     res_valid,
  input  logic     res_ready,
  output bds_res_t res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.fire && ctl.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.emit) begin
      res <= result;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bds_core.sv
// Sequencer state and the per-byte frame decode, staging and CRC update.
// Depends on bds_pkg and bds_crc.
`default_nettype none

module bds_core
  import bds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        code_limit_we,
  input  logic [15:0] code_limit_wdata,
  input  bds_ctl_t    ctl,
  input  bds_req_t    item,
  output bds_res_t    result,
  output logic        emit
);

  logic [15:0] code_limit;
  phase_t      phase, phase_next;
  logic [7:0]  frame_count, frame_count_next;
  logic [7:0]  service_id, service_id_next;
  logic [7:0]  first_arg, first_arg_next;
  logic [7:0]  second_arg, second_arg_next;
  logic [15:0] image_size, image_size_next;
  logic [15:0] bytes_done, bytes_done_next;
  logic [7:0]  page_number, page_number_next;
  logic [15:0] crc_committed, crc_committed_next;
  logic [15:0] crc_pending, crc_pending_next;

  logic [7:0]  sid_eff, first_eff, second_eff, fc_inc, pos_m1;
  logic [15:0] pending_base, crc_upd, bytes_sum, arg_word;
  logic        stage, ok;

  // Bytes 0..2 of a frame land in the id and argument registers; the decode
  // sees the byte being received as if it were already stored.
  assign sid_eff      = (frame_count == 8'd0) ? item.rx_byte : service_id;
  assign first_eff    = (frame_count == 8'd1) ? item.rx_byte : first_arg;
  assign second_eff   = (frame_count == 8'd2) ? item.rx_byte : second_arg;
  assign pending_base = (frame_count == 8'd0) ? crc_committed : crc_pending;
  assign fc_inc       = (frame_count == 8'hFF) ? 8'hFF : frame_count + 8'd1;
  assign pos_m1       = frame_count - 8'd1;
  assign bytes_sum    = bytes_done + PAGE_STEP;
  assign arg_word     = {first_eff, second_eff};
  assign stage        = (frame_count != 8'd0) && (frame_count <= PAGE_LAST) &&
                        (sid_eff == SID_TRANSFER) && (phase == PH_XFER);

  bds_crc u_crc (
    .crc_in  (pending_base),
    .data    (item.rx_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    phase_next         = phase;
    frame_count_next   = frame_count;
    service_id_next    = service_id;
    first_arg_next     = first_arg;
    second_arg_next    = second_arg;
    image_size_next    = image_size;
    bytes_done_next    = bytes_done;
    page_number_next   = page_number;
    crc_committed_next = crc_committed;
    crc_pending_next   = crc_pending;
    result             = '0;
    emit               = 1'b0;
    ok                 = 1'b0;

    if (item.func) begin
      // Reprogram request from the application: drop any partial frame.
      service_id_next   = SID_SESSION;
      frame_count_next  = 8'd0;
      phase_next        = PH_DLREQ;
      result.resp_valid = 1'b1;
      result.resp_byte  = SID_SESSION + RESP_OFFSET;
      emit              = 1'b1;
    end else begin
      service_id_next  = sid_eff;
      first_arg_next   = first_eff;
      second_arg_next  = second_eff;
      crc_pending_next = stage ? crc_upd : pending_base;
      frame_count_next = fc_inc;
      if (stage) begin
        result.stage_valid  = 1'b1;
        result.stage_offset = pos_m1[6:0];
        result.stage_byte   = item.rx_byte;
        emit                = 1'b1;
      end
      if (item.end_of_frame) begin
        frame_count_next = 8'd0;
        unique case (sid_eff)
          SID_SESSION: begin
            if (first_eff == SUB_PROGRAMMING && fc_inc == 8'd2 && phase == PH_SESSION) begin
              ok         = 1'b1;
              phase_next = PH_DLREQ;
            end
          end
          SID_DOWNLOAD: begin
            if (phase == PH_DLREQ && fc_inc == 8'd3) begin
              image_size_next = arg_word;
              if (arg_word < code_limit) begin
                ok                 = 1'b1;
                phase_next         = PH_XFER;
                bytes_done_next    = 16'd0;
                page_number_next   = 8'd0;
                crc_committed_next = CRC_INIT;
              end
            end
          end
          SID_TRANSFER: begin
            if (phase == PH_XFER && fc_inc == XFER_LEN) begin
              ok                  = 1'b1;
              result.commit_valid = 1'b1;
              result.commit_page  = page_number;
              page_number_next    = page_number + 8'd1;
              bytes_done_next     = bytes_sum;
              crc_committed_next  = crc_pending_next;
              if (bytes_sum == image_size) begin
                phase_next = PH_EXIT;
              end
            end
          end
          SID_EXIT: begin
            if (phase == PH_EXIT && fc_inc == 8'd1) begin
              ok         = 1'b1;
              phase_next = PH_CRC;
            end
          end
          SID_CRC: begin
            if (phase == PH_CRC && fc_inc == 8'd3 && arg_word == crc_committed) begin
              ok               = 1'b1;
              result.start_app = 1'b1;
            end
          end
          default: begin
            ok = 1'b0;
          end
        endcase
        if (sid_eff == SID_CRC || !ok) begin
          phase_next = PH_SESSION;
        end
        result.resp_valid = 1'b1;
        result.resp_byte  = ok ? sid_eff + RESP_OFFSET : RESP_NEG;
        emit              = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_limit    <= MAX_CODE_RESET;
      phase         <= PH_SESSION;
      frame_count   <= 8'd0;
      service_id    <= 8'd0;
      first_arg     <= 8'd0;
      second_arg    <= 8'd0;
      image_size    <= 16'd0;
      bytes_done    <= 16'd0;
      page_number   <= 8'd0;
      crc_committed <= CRC_INIT;
      crc_pending   <= CRC_INIT;
    end else begin
      if (code_limit_we) begin
        code_limit <= code_limit_wdata;
      end
      if (ctl.fire) begin
        phase         <= phase_next;
        frame_count   <= frame_count_next;
        service_id    <= service_id_next;
        first_arg     <= first_arg_next;
        second_arg    <= second_arg_next;
        image_size    <= image_size_next;
        bytes_done    <= bytes_done_next;
        page_number   <= page_number_next;
        crc_committed <= crc_committed_next;
        crc_pending   <= crc_pending_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bootloader_download_sequencer.sv
// Top level of the bootloader download sequencer.
// Depends on bds_pkg, bds_in_reg, bds_core, bds_out_reg and the assertion macro header.
//
// The block takes one request byte per cycle while its results are taken
// without stall, and stalls while a result waits untaken: a request sits
// in the input register until the core consumes it, the core decodes it
// and updates the sequencer state in that same cycle, and any response,
// staging or commit result is written to the result register at the next
// clock edge, where it is held until taken. The input register is released
// in the cycle the core consumes it, so a new request is accepted even
// while a finished result still waits in the result register, as long as
// that result is being taken in the same cycle. A request causes at most
// one result; bytes in the middle of a frame that are not staged cause none.
// The code_limit register is written whenever its write enable is high
// and should only be changed while no request is in flight.
`default_nettype none
`include "bootloader_download_sequencer_defines.svh"

module bootloader_download_sequencer
  import bds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        code_limit_we,
  input  logic [15:0] code_limit_wdata,
  input  logic        req_valid,
  output logic        req_ready,
  input  bds_req_t    req,
  output logic        res_valid,
  input  logic        res_ready,
  output bds_res_t    res
);

  logic     full;
  logic     emit;
  bds_req_t item;
  bds_res_t result;
  bds_ctl_t ctl;
  logic     xfer_ack;
  logic     crc_ack;

  // The core works on the held request whenever the result register is
  // free or is being emptied in this cycle.
  assign ctl.fire = full && (!res_valid || res_ready);
  assign ctl.emit = emit;

  // Positive responses to a transfer and to a CRC check, for the checks below.
  assign xfer_ack = res.resp_valid && (res.resp_byte == SID_TRANSFER + RESP_OFFSET);
  assign crc_ack  = res.resp_valid && (res.resp_byte == SID_CRC + RESP_OFFSET);

  bds_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .ctl       (ctl),
    .full      (full),
    .item      (item)
  );

  bds_core u_core (
    .clk              (clk),
    .rst              (rst),
    .code_limit_we    (code_limit_we),
    .code_limit_wdata (code_limit_wdata),
    .ctl              (ctl),
    .item             (item),
    .result           (result),
    .emit             (emit)
  );

  bds_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .result    (result),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // A request that the core consumes with a result must show up next cycle.
  `BDS_ASSERT_NEXT(a_emit_lands, ctl.fire && ctl.emit, res_valid, "emitted result was lost")
  // A page commit always comes with the positive transfer response.
  `BDS_ASSERT_NOW(a_commit_resp, res_valid && res.commit_valid, xfer_ack, "commit without ack")
  // Starting the application only follows a positive CRC check response.
  `BDS_ASSERT_NOW(a_start_resp, res_valid && res.start_app, crc_ack, "start_app without CRC ack")
  // Every result carries at least a response or a staged byte.
  `BDS_ASSERT_NOW(a_res_nonempty, res_valid, res.resp_valid || res.stage_valid, "empty result")

endmodule

`default_nettype wire
